/* sv/bbc_pkg.sv */
package bbc_pkg;

	// Default number of buffer entries
	localparam int NUM_ENTRIES_DEF = 32;

	// Field widths fixed by the interface
	localparam int ENTRY_W = 5;
	localparam int DEV_W   = 16;
	localparam int BLK_W   = 32;
	localparam int CNT_W   = 8;
	localparam int TICK_W  = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Request modes
	localparam logic [1:0] MODE_GET     = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_PIN     = 2'd2;
	localparam logic [1:0] MODE_UNPIN   = 2'd3;

	// One stored buffer entry
	typedef struct packed {
		logic              valid;
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
		logic [CNT_W-1:0]  cnt;
		logic [TICK_W-1:0] tick;
	} entry_t;

	// Outcome of comparing one entry during a scan
	typedef struct packed {
		logic tag_eq;
		logic free_better;
	} cmp_res_t;

endpackage

/* sv/bbc_tag_ram.sv */
module bbc_tag_ram #(
	parameter int DEPTH = bbc_pkg::NUM_ENTRIES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bbc_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output bbc_pkg::entry_t rdata
);
	import bbc_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/bbc_cmp.sv */
module bbc_cmp (
	input  bbc_pkg::entry_t                    word,
	input  logic [bbc_pkg::DEV_W-1:0]          dev,
	input  logic [bbc_pkg::BLK_W-1:0]          blk,
	input  logic                               best_ok,
	input  logic [bbc_pkg::TICK_W-1:0]         best_tick,
	output bbc_pkg::cmp_res_t                  res
);
	import bbc_pkg::*;

	// Match the tag of a valid entry, and rank a free entry against the oldest so far;
	// on equal ticks the later entry wins
	always_comb begin
		res.tag_eq      = word.valid && (word.dev == dev) && (word.blk == blk);
		res.free_better = (word.cnt == '0) && (!best_ok || (word.tick <= best_tick));
	end

endmodule

/* sv/block_buffer_cache_lru.sv */
// Fully associative buffer tag cache with exact LRU recycling. One item is taken at a
// time: a get walks every entry through the single read port of the tag memory, one
// entry per cycle, and then writes back the hit count or the new tag; release, pin
// and unpin do one read-modify-write, which is skipped when the entry index is out
// of range. in_ready is high only while no item is in progress; a finished result
// waits in the output register and the next item may be accepted meanwhile, but that
// item's result holds the block busy until the waiting one is taken. A get that
// neither hits nor finds an unreferenced entry returns status 1 and changes nothing.
module block_buffer_cache_lru #(
	parameter int NUM_ENTRIES = bbc_pkg::NUM_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [bbc_pkg::DEV_W-1:0]     device,
	input  logic [bbc_pkg::BLK_W-1:0]     block_number,
	input  logic [bbc_pkg::ENTRY_W-1:0]   entry_in,
	input  logic [bbc_pkg::TICK_W-1:0]    current_tick,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bbc_pkg::ENTRY_W-1:0]   entry_out,
	output logic                          hit,
	output logic                          needs_read,
	output logic                          status
);
	import bbc_pkg::*;

	localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST = AW'(NUM_ENTRIES - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_GETWR = 3'd3;
	localparam logic [2:0] S_OPRD  = 3'd4;
	localparam logic [2:0] S_OPWR  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]             state_q;
	logic [1:0]             mode_q;
	logic [DEV_W-1:0]       dev_q;
	logic [BLK_W-1:0]       blk_q;
	logic [ENTRY_W-1:0]     idx_q;
	logic [TICK_W-1:0]      tick_q;
	logic [AW-1:0]          scan_q;
	logic                   rd_ok_s1;
	logic [AW-1:0]          rd_idx_s1;
	logic                   rd_touched_s1;
	logic [NUM_ENTRIES-1:0] touched_q;
	logic                   match_q;
	logic [AW-1:0]          match_idx_q;
	entry_t                 match_word_q;
	logic                   vic_q;
	logic [AW-1:0]          vic_idx_q;
	logic [TICK_W-1:0]      vic_tick_q;
	logic [ENTRY_W-1:0]     res_entry_q;
	logic                   res_hit_q;
	logic                   res_rd_q;
	logic                   res_st_q;
	logic                   out_valid_q;
	logic [ENTRY_W-1:0]     out_entry_q;
	logic                   out_hit_q;
	logic                   out_rd_q;
	logic                   out_st_q;

	logic                   accept;
	logic                   in_range;
	logic [AW-1:0]          ram_raddr;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	entry_t                 ram_wdata;
	entry_t                 ram_rdata;
	entry_t                 rd_word;
	entry_t                 op_word;
	cmp_res_t               cmp;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = 32'(entry_in) < 32'(NUM_ENTRIES);

	bbc_tag_ram #(
		.DEPTH (NUM_ENTRIES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entries never written read as all zero
	assign rd_word = rd_touched_s1 ? ram_rdata : '0;

	bbc_cmp u_cmp (
		.word      (rd_word),
		.dev       (dev_q),
		.blk       (blk_q),
		.best_ok   (vic_q),
		.best_tick (vic_tick_q),
		.res       (cmp)
	);

	// Select the read address: the named entry or the scan position
	always_comb begin
		unique case (state_q)
			S_OPRD:  ram_raddr = AW'(idx_q);
			default: ram_raddr = scan_q;
		endcase
	end

	// Adjust the count of a named entry, and stamp the tick when a release frees it
	always_comb begin
		op_word = rd_word;
		unique case (mode_q)
			MODE_RELEASE: begin
				if (rd_word.cnt != '0) begin
					op_word.cnt = rd_word.cnt - CNT_W'(1);
					if (rd_word.cnt == CNT_W'(1)) begin
						op_word.tick = tick_q;
					end
				end
			end
			MODE_PIN: begin
				if (rd_word.cnt != CNT_MAX) begin
					op_word.cnt = rd_word.cnt + CNT_W'(1);
				end
			end
			MODE_UNPIN: begin
				if (rd_word.cnt != '0) begin
					op_word.cnt = rd_word.cnt - CNT_W'(1);
				end
			end
			default: op_word = rd_word;
		endcase
	end

	// Write back: count update, hit increment or victim retag
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = vic_idx_q;
		ram_wdata = match_word_q;
		unique case (state_q)
			S_OPWR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q);
				ram_wdata = op_word;
			end
			S_GETWR: begin
				if (match_q) begin
					ram_we    = 1'b1;
					ram_waddr = match_idx_q;
					ram_wdata = match_word_q;
					if (match_word_q.cnt != CNT_MAX) begin
						ram_wdata.cnt = match_word_q.cnt + CNT_W'(1);
					end
				end else if (vic_q) begin
					ram_we         = 1'b1;
					ram_waddr      = vic_idx_q;
					ram_wdata.valid = 1'b1;
					ram_wdata.dev  = dev_q;
					ram_wdata.blk  = blk_q;
					ram_wdata.cnt  = CNT_W'(1);
					ram_wdata.tick = vic_tick_q;
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Sequencer and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_ok_s1    <= 1'b0;
			touched_q   <= '0;
			match_q     <= 1'b0;
			vic_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_ok_s1 <= (state_q == S_SCAN);
			if (ram_we) begin
				touched_q[ram_waddr] <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_ok_s1 && cmp.tag_eq) begin
				match_q <= 1'b1;
			end
			if (rd_ok_s1 && cmp.free_better) begin
				vic_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_GET) begin
							state_q <= S_SCAN;
							match_q <= 1'b0;
							vic_q   <= 1'b0;
						end else if (in_range) begin
							state_q <= S_OPRD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (scan_q == LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_GETWR;
				S_GETWR: state_q <= S_FIN;
				S_OPRD:  state_q <= S_OPWR;
				S_OPWR:  state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the item, track the best candidates and build the result
	always_ff @(posedge clk) begin
		rd_idx_s1     <= scan_q;
		rd_touched_s1 <= touched_q[ram_raddr];
		if (accept) begin
			mode_q      <= mode;
			dev_q       <= device;
			blk_q       <= block_number;
			idx_q       <= entry_in;
			tick_q      <= current_tick;
			scan_q      <= '0;
			res_entry_q <= entry_in;
			res_hit_q   <= 1'b0;
			res_rd_q    <= 1'b0;
			res_st_q    <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			scan_q <= scan_q + AW'(1);
		end
		// keep the lowest matching index
		if (rd_ok_s1 && cmp.tag_eq && !match_q) begin
			match_idx_q  <= rd_idx_s1;
			match_word_q <= rd_word;
		end
		if (rd_ok_s1 && cmp.free_better) begin
			vic_idx_q  <= rd_idx_s1;
			vic_tick_q <= rd_word.tick;
		end
		if (state_q == S_GETWR) begin
			if (match_q) begin
				res_entry_q <= ENTRY_W'(match_idx_q);
				res_hit_q   <= 1'b1;
				res_rd_q    <= 1'b0;
				res_st_q    <= 1'b0;
			end else if (vic_q) begin
				res_entry_q <= ENTRY_W'(vic_idx_q);
				res_hit_q   <= 1'b0;
				res_rd_q    <= 1'b1;
				res_st_q    <= 1'b0;
			end else begin
				res_entry_q <= '0;
				res_hit_q   <= 1'b0;
				res_rd_q    <= 1'b0;
				res_st_q    <= 1'b1;
			end
		end
		if ((state_q == S_FIN) && (!out_valid_q || out_ready)) begin
			out_entry_q <= res_entry_q;
			out_hit_q   <= res_hit_q;
			out_rd_q    <= res_rd_q;
			out_st_q    <= res_st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign entry_out  = out_entry_q;
	assign hit        = out_hit_q;
	assign needs_read = out_rd_q;
	assign status     = out_st_q;

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (!hit && !needs_read))
		else $error("failed get result carries hit or needs_read");

	a_hit_or_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && needs_read))
		else $error("result is both hit and needs_read");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_OPWR) || (state_q == S_GETWR)))
		else $error("tag memory written outside a write step");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in progress");

endmodule

/* test/bbc_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the buffer tag cache, keeps its own copy of the
// tag store, predicts every result at the moment its request is taken and
// compares each delivered result with the oldest prediction.
module bbc_checker #(
	parameter int NUM_ENTRIES = bbc_pkg::NUM_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [bbc_pkg::DEV_W-1:0]     device,
	input  logic [bbc_pkg::BLK_W-1:0]     block_number,
	input  logic [bbc_pkg::ENTRY_W-1:0]   entry_in,
	input  logic [bbc_pkg::TICK_W-1:0]    current_tick,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [bbc_pkg::ENTRY_W-1:0]   entry_out,
	input  logic                          hit,
	input  logic                          needs_read,
	input  logic                          status,
	output int                            pending,
	output int                            fail_count
);

	typedef struct packed {
		logic [bbc_pkg::ENTRY_W-1:0] entry;
		logic                        hit;
		logic                        needs_read;
		logic                        status;
	} outcome_t;

	// Shadow copy of the tag store
	logic [bbc_pkg::DEV_W-1:0]  cached_dev [NUM_ENTRIES];
	logic [bbc_pkg::BLK_W-1:0]  cached_blk [NUM_ENTRIES];
	logic                       filled     [NUM_ENTRIES];
	logic [bbc_pkg::CNT_W-1:0]  refs       [NUM_ENTRIES];
	logic [bbc_pkg::TICK_W-1:0] stamp      [NUM_ENTRIES];

	outcome_t expected_outcomes [$];
	int       results_seen;

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		$display("MISMATCH at %0t, result %0d: %s expected %0d got %0d",
			$time, results_seen, what, want_v, got_v);
		fail_count++;
	endtask

	// Apply one request to the shadow store and return the result it should give
	function automatic outcome_t apply_request(
		input logic [1:0]                    req_mode,
		input logic [bbc_pkg::DEV_W-1:0]     dev,
		input logic [bbc_pkg::BLK_W-1:0]     blk,
		input logic [bbc_pkg::ENTRY_W-1:0]   idx,
		input logic [bbc_pkg::TICK_W-1:0]    tick
	);
		outcome_t o;
		int       matched;
		int       victim;
		o = '0;
		if (req_mode == bbc_pkg::MODE_GET) begin
			// lowest matching valid entry wins
			matched = -1;
			for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
				if (filled[i] && cached_dev[i] == dev && cached_blk[i] == blk)
					matched = i;
			end
			if (matched >= 0) begin
				if (refs[matched] != bbc_pkg::CNT_MAX)
					refs[matched] = refs[matched] + 1'b1;
				o.entry = matched[bbc_pkg::ENTRY_W-1:0];
				o.hit   = 1'b1;
			end else begin
				// oldest release among unreferenced entries, ties to the higher index
				victim = -1;
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (refs[i] == '0 && (victim < 0 || stamp[i] <= stamp[victim]))
						victim = i;
				end
				if (victim < 0) begin
					o.status = 1'b1;
				end else begin
					cached_dev[victim] = dev;
					cached_blk[victim] = blk;
					refs[victim]       = 8'd1;
					filled[victim]     = 1'b1;
					o.entry      = victim[bbc_pkg::ENTRY_W-1:0];
					o.needs_read = 1'b1;
				end
			end
		end else begin
			if (idx < NUM_ENTRIES) begin
				case (req_mode)
					bbc_pkg::MODE_RELEASE: begin
						if (refs[idx] != '0) begin
							refs[idx] = refs[idx] - 1'b1;
							if (refs[idx] == '0)
								stamp[idx] = tick;
						end
					end
					bbc_pkg::MODE_PIN: begin
						if (refs[idx] != bbc_pkg::CNT_MAX)
							refs[idx] = refs[idx] + 1'b1;
					end
					default: begin
						if (refs[idx] != '0)
							refs[idx] = refs[idx] - 1'b1;
					end
				endcase
			end
			o.entry = idx;
		end
		return o;
	endfunction

	// Check delivered results first, then predict the newly taken request
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				cached_dev[i] = '0;
				cached_blk[i] = '0;
				filled[i]     = 1'b0;
				refs[i]       = '0;
				stamp[i]      = '0;
			end
			expected_outcomes.delete();
			results_seen = 0;
			fail_count   = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with no request outstanding, entry_out", -1,
						int'(entry_out));
				end else begin
					want = expected_outcomes.pop_front();
					if (entry_out !== want.entry)
						report_mismatch("entry_out", int'(want.entry), int'(entry_out));
					if (hit !== want.hit)
						report_mismatch("hit", int'(want.hit), int'(hit));
					if (needs_read !== want.needs_read)
						report_mismatch("needs_read", int'(want.needs_read), int'(needs_read));
					if (status !== want.status)
						report_mismatch("status", int'(want.status), int'(status));
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				expected_outcomes.push_back(apply_request(mode, device, block_number,
					entry_in, current_tick));
			pending <= expected_outcomes.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

// Drives requests into the buffer tag cache and gives the verdict; all
// prediction and comparison lives in the checker beside the block.
module tb;

	localparam int POOL_SIZE  = 48;
	localparam int MIXED_ITEMS = 920;
	localparam int BURST_LEN  = 258;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [1:0]                    mode;
	logic [bbc_pkg::DEV_W-1:0]     device;
	logic [bbc_pkg::BLK_W-1:0]     block_number;
	logic [bbc_pkg::ENTRY_W-1:0]   entry_in;
	logic [bbc_pkg::TICK_W-1:0]    current_tick;
	logic                          out_valid;
	logic                          out_ready;
	logic [bbc_pkg::ENTRY_W-1:0]   entry_out;
	logic                          hit;
	logic                          needs_read;
	logic                          status;

	int chk_pending;
	int chk_fail;

	// Stimulus state
	logic                      sender_calm;
	logic [bbc_pkg::TICK_W-1:0] tick_now;
	logic [bbc_pkg::DEV_W-1:0]  pool_dev [POOL_SIZE];
	logic [bbc_pkg::BLK_W-1:0]  pool_blk [POOL_SIZE];

	block_buffer_cache_lru dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.device       (device),
		.block_number (block_number),
		.entry_in     (entry_in),
		.current_tick (current_tick),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.entry_out    (entry_out),
		.hit          (hit),
		.needs_read   (needs_read),
		.status       (status)
	);

	bbc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.device       (device),
		.block_number (block_number),
		.entry_in     (entry_in),
		.current_tick (current_tick),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.entry_out    (entry_out),
		.hit          (hit),
		.needs_read   (needs_read),
		.status       (status),
		.pending      (chk_pending),
		.fail_count   (chk_fail)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Give up after a generous fixed time
	initial begin
		#15_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls, two long hold-offs and one calm stretch
	initial begin
		int cyc;
		cyc = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if ((cyc >= 2000 && cyc < 2400) || (cyc >= 25000 && cyc < 25300))
				out_ready <= 1'b0;
			else if (cyc >= 9000 && cyc < 16000)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= 28);
		end
	end

	// Offer one item and hold it until taken
	task automatic offer(
		input logic [1:0]                    m,
		input logic [bbc_pkg::DEV_W-1:0]     d,
		input logic [bbc_pkg::BLK_W-1:0]     b,
		input logic [bbc_pkg::ENTRY_W-1:0]   e,
		input logic [bbc_pkg::TICK_W-1:0]    t
	);
		in_valid     <= 1'b1;
		mode         <= m;
		device       <= d;
		block_number <= b;
		entry_in     <= e;
		current_tick <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// Idle the request side for a random number of cycles
	task automatic sender_gap();
		while (!sender_calm && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold off until every outstanding result has been delivered
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
	endtask

	// Next tick: mostly creeping forward, sometimes extreme or random
	function automatic logic [bbc_pkg::TICK_W-1:0] next_tick();
		case ($urandom_range(0, 19))
			0: return $urandom;
			1: return '1;
			2: return '0;
			default: begin
				tick_now = tick_now + $urandom_range(0, 3);
				return tick_now;
			end
		endcase
	endfunction

	// One random request, weighted towards gets or releases per phase
	task automatic random_request(input int get_w, input int rel_w);
		int                          pick;
		int                          j;
		logic [1:0]                  m;
		logic [bbc_pkg::DEV_W-1:0]   d;
		logic [bbc_pkg::BLK_W-1:0]   b;
		pick = $urandom_range(0, 99);
		if (pick < get_w)
			m = bbc_pkg::MODE_GET;
		else if (pick < get_w + rel_w)
			m = bbc_pkg::MODE_RELEASE;
		else if (pick[0])
			m = bbc_pkg::MODE_PIN;
		else
			m = bbc_pkg::MODE_UNPIN;
		if ($urandom_range(0, 99) < 75) begin
			j = $urandom_range(0, POOL_SIZE - 1);
			d = pool_dev[j];
			b = pool_blk[j];
		end else begin
			d = 16'($urandom);
			b = $urandom;
		end
		offer(m, d, b, 5'($urandom_range(0, 31)), next_tick());
	endtask

	initial begin
		logic [bbc_pkg::DEV_W-1:0]   bd;
		logic [bbc_pkg::BLK_W-1:0]   bb;
		logic [bbc_pkg::ENTRY_W-1:0] be;
		int                          guard;

		in_valid     <= 1'b0;
		mode         <= bbc_pkg::MODE_GET;
		device       <= '0;
		block_number <= '0;
		entry_in     <= '0;
		current_tick <= '0;
		arst_n       <= 1'b0;
		sender_calm  = 1'b0;
		tick_now     = 100;

		// Tag pool: small values for frequent hits, extremes, wide block numbers in odd slots
		for (int j = 0; j < POOL_SIZE; j++) begin
			pool_dev[j] = 16'($urandom_range(0, 3));
			pool_blk[j] = (j % 2) ? $urandom : $urandom_range(0, 63);
		end
		pool_dev[0] = '1;
		pool_blk[0] = '1;
		pool_dev[1] = '0;
		pool_blk[1] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: invalid entries never hit, ties, extremes, every mode
		sender_gap(); offer(bbc_pkg::MODE_GET, '0, '0, '0, '0);
		sender_gap(); offer(bbc_pkg::MODE_GET, '0, '0, '1, '1);
		sender_gap(); offer(bbc_pkg::MODE_GET, '1, '1, '0, '0);
		sender_gap(); offer(bbc_pkg::MODE_GET, '1, '0, '0, '0);
		sender_gap(); offer(bbc_pkg::MODE_GET, '0, '1, '0, '0);
		sender_gap(); offer(bbc_pkg::MODE_PIN, '1, '1, 5'd31, '0);
		sender_gap(); offer(bbc_pkg::MODE_UNPIN, '0, '0, 5'd31, '1);
		sender_gap(); offer(bbc_pkg::MODE_RELEASE, '0, '0, 5'd31, 32'd7);
		sender_gap(); offer(bbc_pkg::MODE_RELEASE, '0, '0, 5'd31, '1);
		// release at zero changes nothing
		sender_gap(); offer(bbc_pkg::MODE_RELEASE, '0, '0, 5'd31, 32'd3);
		sender_gap(); offer(bbc_pkg::MODE_UNPIN, '0, '0, 5'd0, '0);
		// count on an entry that was never tagged
		sender_gap(); offer(bbc_pkg::MODE_PIN, '0, '0, 5'd0, '0);
		sender_gap(); offer(bbc_pkg::MODE_RELEASE, '0, '0, 5'd0, 32'd5);
		sender_gap(); offer(bbc_pkg::MODE_GET, 16'd1, 32'd1, '0, '0);
		sender_gap(); offer(bbc_pkg::MODE_RELEASE, '0, '0, 5'd30, '0);
		// hit on an unreferenced but still tagged entry
		sender_gap(); offer(bbc_pkg::MODE_GET, '0, '0, '0, '0);
		sender_gap(); offer(bbc_pkg::MODE_GET, '1, '1, '0, '0);
		sender_gap(); offer(bbc_pkg::MODE_UNPIN, '0, '0, 5'd30, '0);
		sender_gap(); offer(bbc_pkg::MODE_RELEASE, '0, '0, 5'd30, 32'hAAAA_5555);
		sender_gap(); offer(bbc_pkg::MODE_GET, 16'h5555, 32'h5555_AAAA, 5'd21, '0);
		sender_gap(); offer(bbc_pkg::MODE_GET, 16'hAAAA, 32'hAAAA_5555, 5'd10, '0);
		drain();

		// Repeated gets of one tag drive its count into saturation
		bd = 16'($urandom);
		bb = $urandom;
		for (int k = 0; k < BURST_LEN; k++) begin
			sender_gap();
			offer(bbc_pkg::MODE_GET, bd, bb, 5'($urandom), next_tick());
		end

		// Mixed traffic in phases: fill, drain, balanced, overfill
		for (int r = 0; r < MIXED_ITEMS; r++) begin
			sender_calm = (r >= 100 && r < 350);
			if (r == 450)
				drain();
			if (r == 600) begin
				// pin one entry past the top, then release it past zero
				be = 5'($urandom);
				for (int k = 0; k < BURST_LEN; k++) begin
					sender_gap();
					offer(bbc_pkg::MODE_PIN, 16'($urandom), $urandom, be, next_tick());
				end
				for (int k = 0; k < BURST_LEN; k++) begin
					sender_gap();
					offer(bbc_pkg::MODE_RELEASE, 16'($urandom), $urandom, be, next_tick());
				end
			end
			sender_gap();
			case ((r / 120) % 4)
				0: random_request(70, 15);
				1: random_request(30, 45);
				2: random_request(40, 30);
				default: random_request(85, 5);
			endcase
		end

		// Wait for the last results, then a little longer for strays
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (chk_pending != 0 && guard < 20000);
		repeat (80) @(posedge clk);

		if (chk_fail == 0 && chk_pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
sv/bbc_pkg.sv
sv/bbc_tag_ram.sv
sv/bbc_cmp.sv
sv/block_buffer_cache_lru.sv
test/bbc_checker.sv
test/tb.sv
